>>> design/assert_macros.svh
// Assertion macros shared by the line-minimum counter modules.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define GLM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define GLM_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/glm_pkg.sv
// Shared types and constants of the grid local-minimum counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package glm_pkg;

	// Widths fixed by the pixel and result formats.
	localparam int HEIGHT_W = 4;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W  = 15;
	localparam int RISK_W   = 18;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

	// Reset value of both size registers.
	localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

	// Per-pixel control carried from the scan stage to the judging stage.
	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                c_gt0;     // a left neighbour exists
		logic                c_gt1;     // a pixel two to the left exists
		logic                r_ge1;     // a row above exists
		logic                r_ge2;     // two rows above exist
		logic                row_end;   // last pixel of its row
		logic                final_row; // pixel lies in the last row
		logic                frame_end; // last pixel of the frame
		logic                fwd;       // prefetched column-0 value is this pixel
	} pix_ctl_t;

endpackage

>>> design/grid_local_minimum_counter_top.sv
// Top level of the grid local-minimum counter.
// Depends on glm_pkg, glm_scan, glm_line_store and glm_judge.
`timescale 1ns / 1ps

// Usage:
// Height digits of a raster enter on height with in_valid/in_ready, one
// request per pixel in row-major order. The frame size comes from the
// row_width and row_count registers, written through cfg_write, cfg_index and
// cfg_data while no request is in flight.
// A pixel counts as a low point when every 4-connected neighbour inside the
// frame is strictly higher. After the last pixel of a frame one request leaves
// on out_valid/out_ready with low_point_count and risk_sum (sum of height plus
// one over the low points); the next frame starts at once.
// Throughput is one pixel per cycle outside the clearing pass and result stalls,
// set by the line store taking one write and two reads in every cycle. The
// result register is loaded when the last pixel leaves the judging stage.
// After reset the line store is cleared one entry a cycle, all 2 * 2**CW entries
// (256 at the defaults), and in_ready stays low until the pass ends.
// When the receiver stalls, pixels keep flowing until the next frame end meets
// the still occupied result register; in_ready then drops until it is taken.
module grid_local_minimum_counter_top #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_ROWS  = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [glm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [glm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [glm_pkg::HEIGHT_W-1:0]  height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [glm_pkg::COUNT_W-1:0]   low_point_count,
	output logic [glm_pkg::RISK_W-1:0]    risk_sum
);
	import glm_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW = CW + 1;

	logic                s1_free;
	logic                fire;
	pix_ctl_t            ctl;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [HEIGHT_W-1:0] mem_wd;
	logic                mem_re;
	logic [AW-1:0]       mem_ra_a;
	logic [AW-1:0]       mem_ra_b;
	logic [HEIGHT_W-1:0] rd_up;
	logic [HEIGHT_W-1:0] rd_b;

	// Position tracking and store addressing.
	glm_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.CW        (CW),
		.AW        (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.height    (height),
		.s1_free   (s1_free),
		.fire      (fire),
		.ctl       (ctl),
		.mem_we    (mem_we),
		.mem_wa    (mem_wa),
		.mem_wd    (mem_wd),
		.mem_re    (mem_re),
		.mem_ra_a  (mem_ra_a),
		.mem_ra_b  (mem_ra_b)
	);

	// Current and previous row, selected by row parity.
	glm_line_store #(
		.AW (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.wa   (mem_wa),
		.wd   (mem_wd),
		.re   (mem_re),
		.ra_a (mem_ra_a),
		.ra_b (mem_ra_b),
		.rd_a (rd_up),
		.rd_b (rd_b)
	);

	// Decisions, totals and result register.
	glm_judge u_judge (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.ctl             (ctl),
		.rd_up           (rd_up),
		.rd_b            (rd_b),
		.s1_free         (s1_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.low_point_count (low_point_count),
		.risk_sum        (risk_sum)
	);

endmodule

>>> design/glm_line_store.sv
// Two-row line store: one write port and two registered read ports.
// Depends on glm_pkg for the pixel width.
`timescale 1ns / 1ps

module glm_line_store #(
	parameter int AW = 8
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                wa,
	input  logic [glm_pkg::HEIGHT_W-1:0] wd,
	input  logic                         re,
	input  logic [AW-1:0]                ra_a,
	input  logic [AW-1:0]                ra_b,
	output logic [glm_pkg::HEIGHT_W-1:0] rd_a,
	output logic [glm_pkg::HEIGHT_W-1:0] rd_b
);
	import glm_pkg::*;

	localparam int DEPTH = 2 ** AW;

	logic [HEIGHT_W-1:0] mem [DEPTH];

	// Read-first: a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_a <= mem[ra_a];
			rd_b <= mem[ra_b];
		end
	end

endmodule

>>> design/glm_scan.sv
// Scan stage: size registers, raster position counters, line store addressing
// and the clearing pass after reset. Depends on glm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glm_scan #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_ROWS  = 128,
	parameter int CW        = 7,
	parameter int AW        = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [glm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [glm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [glm_pkg::HEIGHT_W-1:0]  height,
	input  logic                          s1_free,
	output logic                          fire,
	output glm_pkg::pix_ctl_t             ctl,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_wa,
	output logic [glm_pkg::HEIGHT_W-1:0]  mem_wd,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_ra_a,
	output logic [AW-1:0]                 mem_ra_b
);
	import glm_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_ROWS + 1);

	logic [CFG_W-1:0] row_width_q;
	logic [CFG_W-1:0] row_count_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;

	logic [WW-1:0] width_eff;
	logic [HW-1:0] rows_eff;
	logic          row_end;
	logic          final_row;
	logic          frame_end;

	// Size registers; the user writes them only between requests, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= SIZE_RESET;
			row_count_q <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_data;
				REG_ROW_COUNT: row_count_q <= cfg_data;
			endcase
		end
	end

	// Effective sizes: zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (row_width_q == '0) begin
			width_eff = WW'(1);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(row_width_q);
		end
		if (row_count_q == '0) begin
			rows_eff = HW'(1);
		end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
			rows_eff = HW'(MAX_ROWS);
		end else begin
			rows_eff = HW'(row_count_q);
		end
	end

	// Position flags of the pixel on offer.
	assign row_end   = (32'(col_q) + 32'd1) >= 32'(width_eff);
	assign final_row = (32'(row_q) + 32'd1) >= 32'(rows_eff);
	assign frame_end = row_end && final_row;

	assign in_ready = !clr_busy_q && s1_free;
	assign fire     = in_valid && in_ready;

	always_comb begin
		ctl.height    = height;
		ctl.c_gt0     = (col_q != '0);
		ctl.c_gt1     = 32'(col_q) >= 32'd2;
		ctl.r_ge1     = (row_q != '0);
		ctl.r_ge2     = 32'(row_q) >= 32'd2;
		ctl.row_end   = row_end;
		ctl.final_row = final_row;
		ctl.frame_end = frame_end;
		ctl.fwd       = row_end && (col_q == '0);
	end

	// Clearing pass over the whole store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Raster position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(32'(col_q) + 32'd1);
			end
		end
	end

	// Store the pixel in its row slot; port A fetches the row above the
	// previous row, port B the right neighbour above or, at a row end, the
	// first pixel of this row for the next row.
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_we = fire;
			mem_wa = {row_q[0], col_q};
			mem_wd = height;
		end
		mem_re   = fire;
		mem_ra_a = {row_q[0], col_q};
		if (row_end) begin
			mem_ra_b = {row_q[0], CW'(0)};
		end else begin
			mem_ra_b = {~row_q[0], CW'(32'(col_q) + 32'd1)};
		end
	end

	`GLM_ASSERT_ALWAYS(a_no_take_while_clearing, clr_busy_q |-> !in_ready, "pixel taken during clearing pass")
	`GLM_ASSERT(a_frame_restart, fire && frame_end |=> (col_q == '0) && (row_q == '0), "position not cleared after frame end")

endmodule

>>> design/glm_judge.sv
// Judging stage: neighbour window registers, low-point decisions, running
// totals and the result register. Depends on glm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glm_judge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  glm_pkg::pix_ctl_t            ctl,
	input  logic [glm_pkg::HEIGHT_W-1:0] rd_up,
	input  logic [glm_pkg::HEIGHT_W-1:0] rd_b,
	output logic                         s1_free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [glm_pkg::COUNT_W-1:0]  low_point_count,
	output logic [glm_pkg::RISK_W-1:0]   risk_sum
);
	import glm_pkg::*;

	logic                s1_valid_q;
	pix_ctl_t            ctl_s1;
	logic [HEIGHT_W-1:0] pf_q;      // column 0 of the previous row
	logic [HEIGHT_W-1:0] nxt_q;     // above-right read of the previous pixel
	logic [HEIGHT_W-1:0] t_prev_q;  // pixel above the previous pixel
	logic [HEIGHT_W-1:0] pp0_q;
	logic [HEIGHT_W-1:0] pp1_q;
	logic [COUNT_W-1:0]  count_q;
	logic [RISK_W-1:0]   risk_q;
	logic                out_valid_q;

	logic                s1_go;
	logic [HEIGHT_W-1:0] h;
	logic [HEIGHT_W-1:0] t_cur;
	logic                j_above;
	logic                j_left;
	logic                j_here;
	logic [1:0]          add_cnt;
	logic [6:0]          add_risk;

	// The stage only waits when a frame result meets a full result register.
	assign s1_go   = s1_valid_q && !(ctl_s1.frame_end && out_valid_q && !out_ready);
	assign s1_free = !s1_valid_q || s1_go;

	assign h     = ctl_s1.height;
	assign t_cur = ctl_s1.c_gt0 ? nxt_q : pf_q;

	// Three candidates: the pixel above, the left pixel in the final row, and
	// the last pixel of the frame itself.
	always_comb begin
		j_above = ctl_s1.r_ge1 && (!ctl_s1.r_ge2 || rd_up > t_cur) && (h > t_cur)
			&& (!ctl_s1.c_gt0 || t_prev_q > t_cur)
			&& (ctl_s1.row_end || rd_b > t_cur);
		j_left = ctl_s1.final_row && ctl_s1.c_gt0
			&& (!ctl_s1.r_ge1 || t_prev_q > pp0_q)
			&& (!ctl_s1.c_gt1 || pp1_q > pp0_q) && (h > pp0_q);
		j_here = ctl_s1.frame_end && (!ctl_s1.r_ge1 || t_cur > h)
			&& (!ctl_s1.c_gt0 || pp0_q > h);
		add_cnt = {1'b0, j_above} + {1'b0, j_left} + {1'b0, j_here};
		add_risk = (j_above ? 7'(t_cur) + 7'd1 : 7'd0)
			+ (j_left ? 7'(pp0_q) + 7'd1 : 7'd0)
			+ (j_here ? 7'(h) + 7'd1 : 7'd0);
	end

	// Stage valid and captured pixel control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s1 <= ctl;
		end
	end

	// Window registers slide along the row above.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			t_prev_q <= t_cur;
			if (ctl_s1.row_end) begin
				pf_q <= ctl_s1.fwd ? h : rd_b;
			end else begin
				nxt_q <= rd_b;
			end
		end
	end

	// Two previous pixels of the current row, totals and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp0_q       <= '0;
			pp1_q       <= '0;
			count_q     <= '0;
			risk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_go) begin
				pp1_q <= pp0_q;
				pp0_q <= h;
				if (ctl_s1.frame_end) begin
					count_q     <= '0;
					risk_q      <= '0;
					out_valid_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_W'(add_cnt);
					risk_q  <= risk_q + RISK_W'(add_risk);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctl_s1.frame_end) begin
			low_point_count <= count_q + COUNT_W'(add_cnt);
			risk_sum        <= risk_q + RISK_W'(add_risk);
		end
	end

	assign out_valid = out_valid_q;

	`GLM_ASSERT(a_stall_cause, s1_valid_q && !s1_go |-> ctl_s1.frame_end && out_valid_q && !out_ready, "stage held without a blocked result")
	`GLM_ASSERT(a_result_loaded, s1_go && ctl_s1.frame_end |=> out_valid_q, "frame end left no result")

endmodule
